[rtl/mexp_pkg.sv]
`default_nettype none
package mexp_pkg;
	localparam int MOD_W = 31;
	localparam int BASE_W = 32;
	localparam int EXP_W = 63;
	localparam int STEP_W = 5;
	localparam logic [MOD_W-1:0] MOD_RESET = 31'd1000000007;

	typedef logic [MOD_W-1:0] res_t;
endpackage
`default_nettype wire

[rtl/modular_exponentiation.sv]
// Modular exponentiation, square and multiply, MSB of the exponent first.
// Steps: reduction of the base, then per exponent bit a squaring plus a multiply by the base
// when the bit is set, then the output register.
// One item at a time: the next input can be taken in the cycle the result is posted; a
// modulus below two skips the reduction and the multiplies and posts 0.
// Reset (arst_n low, asynchronous): idle, no result pending, modulus 1000000007.
`default_nettype none
module modular_exponentiation
	import mexp_pkg::*;
#(
	parameter int EXP_BITS = 63
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // base[31:0], exponent[94:32], zero fill
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // power[30:0], zero fill
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [MOD_W-1:0] cfg_data  // modulus
);
	localparam int EC_W = $clog2(EXP_BITS) + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RED  = 3'd1;
	localparam logic [2:0] S_SQ   = 3'd2;
	localparam logic [2:0] S_MU   = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]          state_q;
	logic [MOD_W-1:0]    mod_q;
	logic [BASE_W-1:0]   base_q;
	logic [EXP_BITS-1:0] e_q;
	logic [EC_W-1:0]     ecnt_q;
	logic [STEP_W-1:0]   step_q;
	res_t                acc_q, r_q, b_q, y_q, out_q;
	logic                out_valid_q;

	logic [MOD_W+1:0] t, t1, m1, m2;
	logic [MOD_W-1:0] x;
	logic             din;
	res_t             red;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {1'b0, out_q};

	// Shift one digit in: acc*2 plus running value or base bit, then reduce below the modulus
	always_comb begin
		x   = r_q;
		din = y_q[MOD_W-1];
		m1  = {2'b00, mod_q};
		m2  = {1'b0, mod_q, 1'b0};
		if (state_q == S_RED)
			t = {1'b0, acc_q, base_q[BASE_W-1]};
		else
			t = {1'b0, acc_q, 1'b0} + (din ? {2'b00, x} : '0);
		if (t >= m2)
			t1 = t - m2;
		else if (t >= m1)
			t1 = t - m1;
		else
			t1 = t;
		red = t1[MOD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mod_q       <= MOD_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				mod_q <= cfg_data;
			// Post the finished result, drop it once the output transaction completes
			if (state_q == S_FIN && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						base_q <= s_tdata[BASE_W-1:0];
						e_q    <= s_tdata[BASE_W +: EXP_BITS];
						ecnt_q <= EC_W'(EXP_BITS);
						acc_q  <= '0;
						step_q <= STEP_W'(BASE_W - 1);
						if (mod_q < MOD_W'(2)) begin
							r_q     <= '0;
							state_q <= S_FIN;
						end else begin
							state_q <= S_RED;
						end
					end
				end
				S_RED: begin
					base_q <= base_q << 1;
					if (step_q == '0) begin
						b_q     <= red;
						r_q     <= MOD_W'(1);
						y_q     <= MOD_W'(1);
						acc_q   <= '0;
						step_q  <= STEP_W'(MOD_W - 1);
						state_q <= S_SQ;
					end else begin
						acc_q  <= red;
						step_q <= step_q - 1'b1;
					end
				end
				S_SQ, S_MU: begin
					if (step_q == '0) begin
						// Multiply done: commit, then multiply, next bit or finish
						r_q    <= red;
						acc_q  <= '0;
						step_q <= STEP_W'(MOD_W - 1);
						if (state_q == S_SQ && e_q[EXP_BITS-1]) begin
							y_q     <= b_q;
							state_q <= S_MU;
						end else begin
							y_q    <= red;
							e_q    <= e_q << 1;
							ecnt_q <= ecnt_q - 1'b1;
							state_q <= (ecnt_q == EC_W'(1)) ? S_FIN : S_SQ;
						end
					end else begin
						acc_q  <= red;
						y_q    <= y_q << 1;
						step_q <= step_q - 1'b1;
					end
				end
				S_FIN: begin
					if (!out_valid_q || m_tready) begin
						out_q   <= r_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Running value, base and partial product stay reduced while multiplying
	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQ || state_q == S_MU) |-> acc_q < mod_q)
		else $error("partial product not reduced");
	a_r_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SQ || state_q == S_MU) |-> r_q < mod_q && b_q < mod_q)
		else $error("operand not reduced");
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && (!out_valid_q || m_tready)) |=> out_valid_q)
		else $error("finished result not posted");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready)
		else $error("input taken while busy");
endmodule
`default_nettype wire

[sim/tb_modular_exponentiation.sv]
`default_nettype none
module tb_modular_exponentiation;
	import mexp_pkg::*;

	// Expected powers waiting for their output transaction
	class power_scoreboard;
		res_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		// Compute base^exponent mod modulus by square and multiply, MSB first
		static function res_t mod_power(logic [MOD_W-1:0] m, logic [BASE_W-1:0] b,
				logic [EXP_W-1:0] e);
			logic [63:0] acc;
			logic [63:0] bb;
			int i;
			if (m < 2) return '0;
			bb = b % m;
			acc = 1;
			for (i = EXP_W - 1; i >= 0; i--) begin
				acc = (acc * acc) % m;
				if (e[i]) acc = (acc * bb) % m;
			end
			return acc[MOD_W-1:0];
		endfunction

		function void note_input(logic [MOD_W-1:0] m, logic [BASE_W-1:0] b,
				logic [EXP_W-1:0] e);
			pending.insert(pending.size(), mod_power(m, b, e));
		endfunction

		function void check_power(logic [31:0] data);
			res_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected power %0d", $time, data[30:0]);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (data[30:0] !== want || data[31] !== 1'b0) begin
				$display("%0t: power mismatch expected %0d actual %0d", $time, want, data);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [95:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [31:0] m_tdata;
	logic cfg_valid;
	logic cfg_ready;
	logic [MOD_W-1:0] cfg_data;

	power_scoreboard sb;
	logic [MOD_W-1:0] cur_mod;
	bit drain_mode;
	bit hold_sink;
	int cycle_count;

	modular_exponentiation dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Write the modulus while the block is idle
	task automatic write_modulus(logic [MOD_W-1:0] m);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_data <= m;
		do @(posedge clk); while (!cfg_ready);
		cur_mod = m;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// Offer one item, with an optional random gap before it
	task automatic send_item(logic [BASE_W-1:0] b, logic [EXP_W-1:0] e, bit gaps);
		int n;
		if (gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			n = $urandom_range(1, 14);
			repeat (n) @(negedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {1'b0, e, b};
		do @(posedge clk); while (!s_tready);
		sb.note_input(cur_mod, b, e);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		@(negedge clk);
		s_tvalid <= 0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (2100) @(negedge clk);
	endtask

	// Some exponents are small or zero to keep the run short, most use the full width
	function automatic logic [EXP_W-1:0] rand_exp();
		logic [63:0] r;
		logic [EXP_W-1:0] e;
		r = {$urandom, $urandom};
		e = r[EXP_W-1:0];
		case ($urandom_range(0, 9))
			0, 1: e = e & 63'hFF;
			2: e = e & 63'hF;
			3: e = '0;
			default: ;
		endcase
		return e;
	endfunction

	function automatic logic [BASE_W-1:0] rand_base();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 32'hFFFF_FFFF;
			2: return {1'b0, cur_mod};
			default: return $urandom;
		endcase
	endfunction

	// Sink: random back-pressure, and check each output transaction
	initial begin
		int n;
		m_tready = 0;
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				m_tready <= 0;
			end else if (!drain_mode && $urandom_range(0, 5) == 0) begin
				m_tready <= 0;
				n = $urandom_range(1, 14);
				repeat (n - 1) @(negedge clk);
			end else begin
				m_tready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_power(m_tdata);
	end

	// Cycle limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 20000000) begin
			$display("[modular_exponentiation] ERROR");
			$finish;
		end
	end

	initial begin
		logic [MOD_W-1:0] mods[6];
		int i;
		int k;
		sb = new();
		s_tvalid = 0;
		s_tdata = '0;
		cfg_valid = 0;
		cfg_data = '0;
		drain_mode = 0;
		hold_sink = 0;
		cur_mod = MOD_RESET;
		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: reset modulus, exponent zero and one, field extremes
		send_item(0, 0, 0);
		send_item(32'hFFFF_FFFF, 0, 0);
		send_item(32'hFFFF_FFFF, 1, 0);
		send_item(12345, 1, 0);
		send_item(2, 10, 0);
		send_item(32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 0);
		send_item(0, 63'h7FFF_FFFF_FFFF_FFFF, 0);
		send_item(1000000007, 5, 0);
		wait_drain();
		write_modulus(2);
		send_item(3, 63'h7FFF_FFFF_FFFF_FFFF, 0);
		send_item(4, 1, 0);
		send_item(5, 0, 0);
		wait_drain();
		write_modulus(31'h7FFF_FFFF);
		send_item(32'hFFFF_FFFF, 63'h7FFF_FFFF_FFFF_FFFF, 0);
		send_item(31'h7FFF_FFFE, 2, 0);
		send_item(32'h8000_0000, 1, 0);
		wait_drain();
		// Moduli below two give zero
		write_modulus(1);
		send_item(7, 0, 0);
		send_item(7, 3, 0);
		wait_drain();
		write_modulus(0);
		send_item(9, 0, 0);
		send_item(9, 5, 0);
		wait_drain();

		// Random phases over several moduli
		mods = '{31'd13, 31'd1000000007, 31'h7FFF_FFFF, 31'd65537, 31'd3, 31'd0};
		for (k = 0; k < 6; k++) begin
			if (k == 5) mods[k] = MOD_W'($urandom_range(2, 32'h7FFF_FFFF));
			write_modulus(mods[k]);
			if (k == 1) begin
				// Hold the sink off while the source keeps offering items
				hold_sink = 1;
				fork
					begin
						repeat (3000) @(negedge clk);
						hold_sink = 0;
					end
					for (i = 0; i < 6; i++)
						send_item(rand_base(), EXP_W'($urandom_range(0, 7)), 0);
				join
			end
			if (k == 5) drain_mode = 1;
			for (i = 0; i < 120; i++) send_item(rand_base(), rand_exp(), k != 5);
			wait_drain();
		end
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("[modular_exponentiation] OK");
		end else begin
			if (sb.pending.size() != 0)
				$display("%0t: %0d expected powers never arrived", $time, sb.pending.size());
			$display("[modular_exponentiation] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
